// ===== sv/sstf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types, constants, font table and microcode for the seven-segment
// text formatter.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int MAX_LEN   = 64;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int POS_W     = ADDR_W + 1;
  localparam int CHAR_W    = 8;
  localparam int SEG_W     = 8;
  localparam int DIGITS    = 4;
  localparam int CNT_W     = $clog2(DIGITS + 1);
  localparam int POINT_BIT = 7;

  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 48;

  localparam logic [CHAR_W-1:0] CODE_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CODE_COLON = 8'h3A;
  localparam logic [CNT_W-1:0]  COLON_SLOT = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(DIGITS);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [SEG_W-1:0] segs;
  } font_t;

  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_START = 3'd1,
    STEP_LOOP  = 3'd2,
    STEP_EVAL  = 3'd3,
    STEP_PAST  = 3'd4,
    STEP_EMIT  = 3'd5
  } step_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_PAST,
    OP_EVAL,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_RENDER,
    CND_EMPTY_WRAP,
    CND_HAVE_CHAR,
    CND_DIGITS_DONE,
    CND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  accept;
    op_e   op;
    cond_e cond;
    step_e next_t;
    step_e next_f;
  } uword_t;

  function automatic uword_t ucode(input step_e step);
    uword_t w;
    w = '{1'b0, OP_NONE, CND_ALWAYS, STEP_IDLE, STEP_IDLE};
    case (step)
      STEP_IDLE:  w = '{1'b1, OP_ACCEPT, CND_RENDER,      STEP_START, STEP_IDLE};
      STEP_START: w = '{1'b0, OP_NONE,   CND_EMPTY_WRAP,  STEP_EMIT,  STEP_LOOP};
      STEP_LOOP:  w = '{1'b0, OP_NONE,   CND_HAVE_CHAR,   STEP_EVAL,  STEP_PAST};
      STEP_EVAL:  w = '{1'b0, OP_EVAL,   CND_DIGITS_DONE, STEP_EMIT,  STEP_LOOP};
      STEP_PAST:  w = '{1'b0, OP_PAST,   CND_DIGITS_DONE, STEP_EMIT,  STEP_LOOP};
      STEP_EMIT:  w = '{1'b0, OP_EMIT,   CND_OUT_FREE,    STEP_IDLE,  STEP_EMIT};
      default:    w = '{1'b0, OP_NONE,   CND_ALWAYS,      STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic font_t font_lookup(input logic [CHAR_W-1:0] code);
    font_t f;
    f.hit = 1'b1;
    case (code)
      8'h30:   f.segs = 8'h3F;
      8'h31:   f.segs = 8'h06;
      8'h32:   f.segs = 8'h5B;
      8'h33:   f.segs = 8'h4F;
      8'h34:   f.segs = 8'h66;
      8'h35:   f.segs = 8'h6D;
      8'h36:   f.segs = 8'h7D;
      8'h37:   f.segs = 8'h07;
      8'h38:   f.segs = 8'h7F;
      8'h39:   f.segs = 8'h6F;
      8'h20:   f.segs = 8'h00;
      8'h41:   f.segs = 8'h77;
      8'h62:   f.segs = 8'h7C;
      8'h43:   f.segs = 8'h39;
      8'h63:   f.segs = 8'h58;
      8'h64:   f.segs = 8'h5E;
      8'h45:   f.segs = 8'h79;
      8'h46:   f.segs = 8'h71;
      8'h47:   f.segs = 8'h3D;
      8'h48:   f.segs = 8'h76;
      8'h68:   f.segs = 8'h74;
      8'h49:   f.segs = 8'h30;
      8'h4A:   f.segs = 8'h0E;
      8'h4C:   f.segs = 8'h38;
      8'h4E:   f.segs = 8'h37;
      8'h4F:   f.segs = 8'h3F;
      8'h6F:   f.segs = 8'h5C;
      8'h50:   f.segs = 8'h73;
      8'h72:   f.segs = 8'h50;
      8'h53:   f.segs = 8'h6D;
      8'h74:   f.segs = 8'h78;
      8'h55:   f.segs = 8'h3E;
      8'h75:   f.segs = 8'h1C;
      8'h59:   f.segs = 8'h6E;
      default: begin
        f.hit  = 1'b0;
        f.segs = 8'h00;
      end
    endcase
    return f;
  endfunction

endpackage

// ===== sv/seven_segment_text_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_text_formatter
// Stores a text message and renders four seven-segment digits from it.
// ----------------------------------------------------------------------------
// Usage: the slave stream takes items; tuser selects load (0) or render (1).
// A load writes tdata[13:6] into message slot tdata[5:0]; with tlast set the
// message length becomes that slot plus one. A load gives no
// result. A render starts at position tdata[19:14] and gives one result item
// on the master stream: four digit bytes, colon flag, next position and the
// leading-period flag.
// A render runs a six-step microcode program: a read step and an evaluate
// step per character read from the message RAM, per blank or wrap step past
// the end and for the final trailing-period check; an empty wrapped message
// goes straight from the start step to the emit step. The input is not
// accepted while a render runs.
// The result sits in an output register, so the next item is accepted while
// a result waits; a render that finishes while the receiver stalls holds in
// its last step until the output register frees.
// Reset clears the message length, the wrap mode and the output valid; the
// message RAM holds no reset value.
// ----------------------------------------------------------------------------
module seven_segment_text_formatter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,    // continuous_wrap
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // char_index[5:0], char_code[13:6], start_pos[19:14], zero fill
  input  logic [sstf_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tlast_i, // is_last
  input  logic                          s_axis_tuser_i, // kind
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // digit0[7:0], digit1[15:8], digit2[23:16], digit3[31:24], colon_on[32],
  // next_pos[39:33], leading_dot_skipped[40], zero fill
  output logic [sstf_pkg::M_DATA_W-1:0] m_axis_tdata_o
);

  localparam int AW = sstf_pkg::ADDR_W;
  localparam int PW = sstf_pkg::POS_W;
  localparam int CW = sstf_pkg::CNT_W;
  localparam int SW = sstf_pkg::SEG_W;

  sstf_pkg::step_e  step_q, step_d;
  sstf_pkg::uword_t uw;
  logic             cond;

  logic          wrap_q;
  logic [PW-1:0] len_q;
  logic          m_valid_q;
  logic          out_free;
  logic          s_fire;
  logic          is_load;
  logic          is_render;

  logic [AW-1:0]                  in_idx;
  logic [sstf_pkg::CHAR_W-1:0]    in_code;
  logic [AW-1:0]                  in_start;

  logic [PW-1:0] pos_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    dig_sel;
  logic [1:0]    prev_sel;
  logic          special_q;
  logic          colon_q;
  logic          skipped_q;
  logic [SW-1:0] dig_q [sstf_pkg::DIGITS];
  logic [sstf_pkg::M_DATA_W-1:0] m_data_q;

  logic [sstf_pkg::CHAR_W-1:0] rd_char;
  sstf_pkg::font_t             font;

  assign in_idx   = s_axis_tdata_i[AW-1:0];
  assign in_code  = s_axis_tdata_i[AW+sstf_pkg::CHAR_W-1:AW];
  assign in_start = s_axis_tdata_i[2*AW+sstf_pkg::CHAR_W-1:AW+sstf_pkg::CHAR_W];

  assign uw              = sstf_pkg::ucode(step_q);
  assign s_axis_tready_o = uw.accept;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load         = s_fire && (s_axis_tuser_i == sstf_pkg::KIND_LOAD);
  assign is_render       = s_fire && (s_axis_tuser_i == sstf_pkg::KIND_RENDER);
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign dig_sel  = cnt_q[1:0];
  assign prev_sel = cnt_q[1:0] - 2'd1;
  assign font     = sstf_pkg::font_lookup(rd_char);

  sstf_ram #(
    .WIDTH (sstf_pkg::CHAR_W),
    .DEPTH (sstf_pkg::MAX_LEN)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (is_load),
    .waddr_i (in_idx),
    .wdata_i (in_code),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (rd_char)
  );

  // branch condition select
  always_comb begin
    case (uw.cond)
      sstf_pkg::CND_ALWAYS:      cond = 1'b1;
      sstf_pkg::CND_RENDER:      cond = is_render;
      sstf_pkg::CND_EMPTY_WRAP:  cond = wrap_q && (len_q == '0);
      sstf_pkg::CND_HAVE_CHAR:   cond = pos_q < len_q;
      sstf_pkg::CND_DIGITS_DONE: cond = cnt_q == sstf_pkg::CNT_FULL;
      sstf_pkg::CND_OUT_FREE:    cond = out_free;
      default:                   cond = 1'b0;
    endcase
    step_d = cond ? uw.next_t : uw.next_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= sstf_pkg::STEP_IDLE;
      wrap_q    <= 1'b0;
      len_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        wrap_q <= cfg_wdata_i;
      end
      if (is_load && s_axis_tlast_i) begin
        len_q <= {1'b0, in_idx} + PW'(1);
      end
      if (uw.op == sstf_pkg::OP_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath driven by the current control word
  always_ff @(posedge clk_i) begin
    case (uw.op)
      sstf_pkg::OP_ACCEPT: begin
        if (is_render) begin
          pos_q     <= {1'b0, in_start};
          cnt_q     <= '0;
          special_q <= 1'b0;
          colon_q   <= 1'b0;
          skipped_q <= 1'b0;
          for (int k = 0; k < sstf_pkg::DIGITS; k++) begin
            dig_q[k] <= '0;
          end
        end
      end
      sstf_pkg::OP_PAST: begin
        if (cnt_q != sstf_pkg::CNT_FULL) begin
          if (wrap_q) begin
            pos_q <= '0;
          end else begin
            dig_q[dig_sel] <= '0;
            cnt_q          <= cnt_q + CW'(1);
          end
        end
      end
      sstf_pkg::OP_EVAL: begin
        if (cnt_q == sstf_pkg::CNT_FULL) begin
          // trailing period
          if (rd_char == sstf_pkg::CODE_DOT) begin
            dig_q[sstf_pkg::DIGITS-1][sstf_pkg::POINT_BIT] <= 1'b1;
            pos_q <= pos_q + PW'(1);
          end
        end else begin
          pos_q <= pos_q + PW'(1);
          if (font.hit) begin
            dig_q[dig_sel] <= font.segs;
            special_q      <= 1'b0;
            cnt_q          <= cnt_q + CW'(1);
          end else if (!special_q && rd_char == sstf_pkg::CODE_COLON &&
                       cnt_q == sstf_pkg::COLON_SLOT) begin
            colon_q   <= 1'b1;
            special_q <= 1'b1;
          end else if (!special_q && rd_char == sstf_pkg::CODE_DOT) begin
            special_q <= 1'b1;
            if (cnt_q != '0) begin
              dig_q[prev_sel][sstf_pkg::POINT_BIT] <= 1'b1;
            end else begin
              skipped_q <= 1'b1;
            end
          end else begin
            dig_q[dig_sel] <= '0;
            special_q      <= 1'b0;
            cnt_q          <= cnt_q + CW'(1);
          end
        end
      end
      sstf_pkg::OP_EMIT: begin
        if (out_free) begin
          m_data_q <= {7'd0, skipped_q, pos_q, colon_q,
                       dig_q[3], dig_q[2], dig_q[1], dig_q[0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/sstf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sstf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/sstf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks for the seven-segment text formatter, bound to the top.
// ----------------------------------------------------------------------------
module sstf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [sstf_pkg::M_DATA_W-1:0] m_axis_tdata_o
);

  logic s_fire;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");

  // a render keeps the input closed in the next cycle
  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser_i == sstf_pkg::KIND_RENDER) |=> !s_axis_tready_o)
    else $error("input open right after a render item");

  // a load never blocks the next item
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser_i == sstf_pkg::KIND_LOAD) |=> s_axis_tready_o)
    else $error("input closed after a load item");

  // next position never passes the message capacity
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[39:33] <= 7'(sstf_pkg::MAX_LEN)))
    else $error("next position out of range");

endmodule

bind seven_segment_text_formatter sstf_checker u_sstf_checker (.*);

// ===== dv/seven_segment_text_formatter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_text_formatter_test
// Loads text messages into the formatter and renders them as four display
// digits. A predictor keeps its own copy of the message, the length and the
// wrap mode, and works out the digits, colon, next position and skipped-period
// flag of every accepted render. Each result item is compared field by field
// with the oldest prediction. Directed items cover the empty message, periods,
// colons and trailing points. Random runs follow in both wrap modes, with
// random gaps and stalls on either stream.
// ----------------------------------------------------------------------------
module seven_segment_text_formatter_test;

  localparam int GLYPHS         = 34;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [GLYPHS*8-1:0] GLYPH_CHARS = "0123456789 AbCcdEFGHhIJLNOoPrStUuY";
  localparam logic [GLYPHS*8-1:0] GLYPH_SEGS  = {
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00, 8'h77,
    8'h7C, 8'h39, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h74, 8'h30, 8'h0E, 8'h38,
    8'h37, 8'h3F, 8'h5C, 8'h73, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h6E};

  typedef struct packed {
    logic       kind;
    logic [5:0] char_index;
    logic [7:0] char_code;
    logic       is_last;
    logic [5:0] start_pos;
  } text_item_t;

  // digit0 in the lowest bits, as on the master stream
  typedef struct packed {
    logic       dot_skipped;
    logic [6:0] next_pos;
    logic       colon_on;
    logic [7:0] digit3;
    logic [7:0] digit2;
    logic [7:0] digit1;
    logic [7:0] digit0;
  } display_t;

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic                          cfg_wdata = 1'b0;
  logic                          s_valid   = 1'b0;
  logic [sstf_pkg::S_DATA_W-1:0] s_data    = '0;
  logic                          s_last    = 1'b0;
  logic                          s_kind    = 1'b0;
  logic                          s_ready;
  logic                          m_valid;
  logic                          m_ready   = 1'b0;
  logic [sstf_pkg::M_DATA_W-1:0] m_data;

  logic [7:0]  msg_store [sstf_pkg::MAX_LEN];
  logic [63:0] slot_written = '0;
  logic [6:0]  msg_len      = '0;
  bit          wrap_mode    = 1'b0;

  display_t queued_displays [$];
  display_t last_display;
  display_t seen_display;
  display_t want_display;

  int fail_count     = 0;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;

  seven_segment_text_formatter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit glyph_of(input logic [7:0] code, output logic [7:0] segs);
    segs = 8'h00;
    for (int k = 0; k < GLYPHS; k++) begin
      if (GLYPH_CHARS[(GLYPHS-1-k)*8 +: 8] == code) begin
        segs = GLYPH_SEGS[(GLYPHS-1-k)*8 +: 8];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic display_t render_digits(input logic [5:0] start);
    logic [7:0]  dig [sstf_pkg::DIGITS];
    logic [7:0]  c;
    logic [7:0]  segs;
    int unsigned pos;
    int unsigned n;
    bit          after_mark;
    bit          colon;
    bit          skipped;
    display_t    r;
    pos        = start;
    n          = 0;
    after_mark = 1'b0;
    colon      = 1'b0;
    skipped    = 1'b0;
    for (int k = 0; k < sstf_pkg::DIGITS; k++) dig[k] = 8'h00;
    if (!(wrap_mode && msg_len == 0)) begin
      while (n < sstf_pkg::DIGITS) begin
        if (pos >= msg_len) begin
          if (wrap_mode) begin
            pos = 0;
          end else begin
            dig[n] = 8'h00;
            n++;
          end
        end else begin
          c = msg_store[pos];
          if (glyph_of(c, segs)) begin
            dig[n]     = segs;
            after_mark = 1'b0;
            n++;
          end else if (!after_mark && c == sstf_pkg::CODE_COLON && n == 2) begin
            colon      = 1'b1;
            after_mark = 1'b1;
          end else if (!after_mark && c == sstf_pkg::CODE_DOT) begin
            after_mark = 1'b1;
            if (n > 0) dig[n-1][sstf_pkg::POINT_BIT] = 1'b1;
            else skipped = 1'b1;
          end else begin
            dig[n]     = 8'h00;
            after_mark = 1'b0;
            n++;
          end
          pos++;
        end
      end
      // trailing period lights the last point
      if (pos < msg_len && msg_store[pos] == sstf_pkg::CODE_DOT) begin
        dig[sstf_pkg::DIGITS-1][sstf_pkg::POINT_BIT] = 1'b1;
        pos++;
      end
    end
    r.digit0      = dig[0];
    r.digit1      = dig[1];
    r.digit2      = dig[2];
    r.digit3      = dig[3];
    r.colon_on    = colon;
    r.next_pos    = 7'(pos);
    r.dot_skipped = skipped;
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return GLYPH_CHARS[$urandom_range(GLYPHS-1)*8 +: 8];
    if (roll < 75) return sstf_pkg::CODE_DOT;
    if (roll < 85) return sstf_pkg::CODE_COLON;
    return 8'($urandom_range(255));
  endfunction

  function automatic text_item_t make_load(input logic [5:0] idx, input logic [7:0] code,
                                           input logic last);
    text_item_t it;
    it.kind       = sstf_pkg::KIND_LOAD;
    it.char_index = idx;
    it.char_code  = code;
    it.is_last    = last;
    it.start_pos  = 6'($urandom_range(63));
    return it;
  endfunction

  function automatic text_item_t make_render(input logic [5:0] start);
    text_item_t it;
    it.kind       = sstf_pkg::KIND_RENDER;
    it.char_index = 6'($urandom_range(63));
    it.char_code  = 8'($urandom_range(255));
    it.is_last    = 1'($urandom_range(1));
    it.start_pos  = start;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  task automatic send_item(input text_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= sstf_pkg::S_DATA_W'({item.start_pos, item.char_code, item.char_index});
    s_last  <= item.is_last;
    s_kind  <= item.kind;
    do @(posedge clk_i); while (s_ready !== 1'b1);
    if (item.kind == sstf_pkg::KIND_LOAD) begin
      msg_store[item.char_index]    = item.char_code;
      slot_written[item.char_index] = 1'b1;
      if (item.is_last) msg_len = 7'(item.char_index) + 7'd1;
    end else begin
      last_display = render_digits(item.start_pos);
      queued_displays.push_back(last_display);
    end
  endtask

  task automatic load_text(input string text);
    for (int k = 0; k < text.len(); k++)
      send_item(make_load(6'(k), text[k], k == text.len() - 1));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (queued_displays.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_wrap(input bit mode);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    wrap_mode = mode;
  endtask

  task automatic run_random_items(input int count);
    int          sent;
    int          len;
    int          reps;
    logic [5:0]  idx;
    logic [5:0]  start;
    logic [63:0] below;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
          for (int k = 0; k < len; k++) send_item(make_load(6'(k), pick_char(), k == len - 1));
          sent += len;
          start = 6'($urandom_range((len + 3 > 63) ? 63 : len + 3));
          reps  = $urandom_range(4, 1);
          for (int r = 0; r < reps; r++) begin
            send_item(make_render(start));
            // follow on from where the last render stopped
            start = (last_display.next_pos < 7'd64) ? last_display.next_pos[5:0]
                                                     : 6'($urandom_range(63));
          end
          sent += reps;
        end
        6, 7: begin
          idx   = 6'($urandom_range(63));
          below = ~64'd0 >> (63 - idx);
          send_item(make_load(idx, 8'($urandom_range(255)),
                              $urandom_range(1) && ((slot_written & below) == below)));
          sent++;
        end
        default: begin
          send_item(make_render(6'($urandom_range(63))));
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_empty_message();
    set_wrap(1'b1);
    send_item(make_render(6'd0));
    send_item(make_render(6'd63));
    set_wrap(1'b0);
    send_item(make_render(6'd17));
  endtask

  task automatic test_marks_and_points();
    // leading period, colon on the third digit, double period, colon elsewhere
    load_text(".12:3..4:5.");
    send_item(make_render(6'd0));
    send_item(make_render(6'd7));
    send_item(make_render(6'd63));
    // trailing period after four digits
    load_text("8888.");
    send_item(make_render(6'd0));
    send_item(make_load(6'd63, 8'hFF, 1'b0));
    send_item(make_load(6'd62, 8'h00, 1'b0));
  endtask

  task automatic test_wrap_off_traffic();
    src_gap_pct    = 30;
    sink_stall_pct = 56;
    set_wrap(1'b0);
    run_random_items(450);
  endtask

  task automatic test_wrap_on_traffic();
    src_gap_pct    = 56;
    sink_stall_pct = 30;
    set_wrap(1'b1);
    run_random_items(225);
    drain_results();
    run_random_items(225);
  endtask

  task automatic test_back_to_back();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    set_wrap(1'b0);
    run_random_items(225);
    set_wrap(1'b1);
    run_random_items(225);
  endtask

  always @(negedge clk_i) m_ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      seen_display = m_data[$bits(display_t)-1:0];
      if (queued_displays.size() == 0) begin
        report_mismatch("unexpected result", 8'h00, 8'h00);
      end else begin
        want_display = queued_displays.pop_front();
        if (seen_display.digit0 !== want_display.digit0)
          report_mismatch("digit0", seen_display.digit0, want_display.digit0);
        if (seen_display.digit1 !== want_display.digit1)
          report_mismatch("digit1", seen_display.digit1, want_display.digit1);
        if (seen_display.digit2 !== want_display.digit2)
          report_mismatch("digit2", seen_display.digit2, want_display.digit2);
        if (seen_display.digit3 !== want_display.digit3)
          report_mismatch("digit3", seen_display.digit3, want_display.digit3);
        if (seen_display.colon_on !== want_display.colon_on)
          report_mismatch("colon_on", 8'(seen_display.colon_on), 8'(want_display.colon_on));
        if (seen_display.next_pos !== want_display.next_pos)
          report_mismatch("next_pos", 8'(seen_display.next_pos), 8'(want_display.next_pos));
        if (seen_display.dot_skipped !== want_display.dot_skipped)
          report_mismatch("leading_dot_skipped", 8'(seen_display.dot_skipped),
                          8'(want_display.dot_skipped));
        if (m_data[sstf_pkg::M_DATA_W-1:$bits(display_t)] !== '0)
          report_mismatch("fill", 8'(m_data[sstf_pkg::M_DATA_W-1:$bits(display_t)]), 8'h00);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_message();
    test_marks_and_points();
    test_wrap_off_traffic();
    test_wrap_on_traffic();
    test_back_to_back();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sstf_pkg.sv
sv/sstf_ram.sv
sv/seven_segment_text_formatter.sv
sv/sstf_checker.sv
dv/seven_segment_text_formatter_test.sv
